@@ hw/rtl/hvcc_pkg.sv @@
// Package with the shared types and constants of the hvcC to Annex B converter.
`timescale 1ns / 1ps

package hvcc_pkg;

    // Number of fixed header bytes that are skipped at the start of a record.
    localparam logic [4:0] HDR_BYTES = 5'd21;

    // Number of bytes in an Annex B start code.
    localparam logic [2:0] START_LEN = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_TRUNC = 2'd2;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_HDR  = 4'd0,
        PH_LSZ  = 4'd1,
        PH_NARR = 4'd2,
        PH_TYPE = 4'd3,
        PH_CNTH = 4'd4,
        PH_CNTL = 4'd5,
        PH_LENH = 4'd6,
        PH_LENL = 4'd7,
        PH_PAY  = 4'd8,
        PH_DONE = 4'd9
    } t_phase;

    // Description of the output beats that one input byte causes.
    typedef struct packed {
        logic       sc;    // emit a start code
        logic       pay;   // emit one payload byte
        logic [7:0] data;  // payload byte
        logic [1:0] stat;  // status kind, KIND_DATA when there is none
    } t_burst;

endpackage

@@ hw/rtl/hvcc_in_if.sv @@
// Input channel: one hvcC record byte per beat.
`timescale 1ns / 1ps

interface hvcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

@@ hw/rtl/hvcc_out_if.sv @@
// Output channel: one Annex B byte or status result per beat.
`timescale 1ns / 1ps

interface hvcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       run_last;

    modport source (output valid, output out_byte, output out_kind, output run_last,
                    input ready);
    modport sink (input valid, input out_byte, input out_kind, input run_last,
                  output ready);
endinterface

@@ hw/rtl/hvcc_extradata_to_annexb_top.sv @@
// Top level of the hvcC to Annex B converter: parser plus output beat register.
//
//   channel   direction  beat contents
//   i_in      in         in_byte, in_last
//   o_out     out        out_byte, out_kind, run_last
//
// A record byte is taken in every cycle while the output keeps up: one payload
// byte per cycle end to end. A length high byte holds the input while its
// four start code beats drain, and a byte marked last adds one status beat.
// The limit is the single output beat register, which holds the beats of one
// input byte.
// Reset is synchronous and active low; it returns the parser to the header.
// A stall on o_out holds the beat in place and stops i_in while that register
// holds any beat.
`timescale 1ns / 1ps

module hvcc_extradata_to_annexb_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hvcc_in_if.sink    i_in,
    hvcc_out_if.source o_out
);
    import hvcc_pkg::*;

    t_burst     w_burst;
    logic       w_take;
    logic       w_has_beats;
    logic       w_pop;
    logic [2:0] w_data_cnt;
    logic [2:0] w_total;
    logic       w_beat_last;
    logic       w_pos_data;

    logic       r_busy;
    t_burst     r_b;
    logic [2:0] r_pos;

    assign w_take = i_in.valid && i_in.ready;

    hvcc_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (i_in.in_byte),
        .i_last  (i_in.in_last),
        .o_burst (w_burst)
    );

    // Beat count of the held burst and position decode.
    assign w_has_beats = w_burst.sc || w_burst.pay || (w_burst.stat != KIND_DATA);
    assign w_data_cnt  = r_b.sc ? START_LEN : {2'b00, r_b.pay};
    assign w_total     = w_data_cnt + {2'b00, (r_b.stat != KIND_DATA)};
    assign w_beat_last = (r_pos == (w_total - 3'd1));
    assign w_pos_data  = (r_pos < w_data_cnt);
    assign w_pop       = r_busy && o_out.ready;

    // Output beat contents.
    assign o_out.valid    = r_busy;
    assign o_out.out_byte = !w_pos_data ? 8'd0 :
                            r_b.sc ? ((r_pos == (START_LEN - 3'd1)) ? 8'd1 : 8'd0) :
                            r_b.data;
    assign o_out.out_kind = w_pos_data ? KIND_DATA : r_b.stat;
    assign o_out.run_last = w_beat_last;

    // A new byte is taken when the register is empty or its final beat leaves.
    assign i_in.ready = !r_busy || (o_out.ready && w_beat_last);

    // Output beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 3'd0;
        end else if (w_take && w_has_beats) begin
            r_busy <= 1'b1;
            r_pos  <= 3'd0;
        end else if (w_pop) begin
            if (w_beat_last) begin
                r_busy <= 1'b0;
                r_pos  <= 3'd0;
            end else begin
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_has_beats) begin
            r_b <= w_burst;
        end
    end

`ifndef SYNTH
    // A byte is taken over a busy register only as its final beat leaves.
    a_take_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_busy) |-> (o_out.ready && w_beat_last))
        else $error("input taken while beats are still pending");

    // The beat position stays inside the held burst.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pos < w_total))
        else $error("beat position beyond burst length");

    // A status beat is always the final beat of its input byte.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (o_out.out_kind != KIND_DATA)) |-> o_out.run_last)
        else $error("status beat not marked last");

    // A partly sent burst keeps its position under an output stall.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !o_out.ready) |=> (r_busy && $stable(r_pos)))
        else $error("beat position moved during a stall");
`endif

endmodule

@@ hw/rtl/hvcc_parse.sv @@
// Record parser: tracks the hvcC structure and describes the beats of each byte.
`timescale 1ns / 1ps

module hvcc_parse (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output hvcc_pkg::t_burst o_burst
);
    import hvcc_pkg::*;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_skip, n_skip;
    logic [7:0]  r_arrays, n_arrays;
    logic [15:0] r_nalus, n_nalus;
    logic [15:0] r_payload, n_payload;

    logic [4:0]  w_skip_inc;
    logic [7:0]  w_arrays_dec;
    logic [15:0] w_nalus_dec;
    logic [15:0] w_nalus_full;
    logic [15:0] w_payload_full;
    logic [15:0] w_payload_dec;
    t_phase      w_after_array;
    t_phase      w_after_nal;
    t_burst      w_burst;

    assign w_skip_inc     = r_skip + 5'd1;
    assign w_arrays_dec   = r_arrays - 8'd1;
    assign w_nalus_dec    = r_nalus - 16'd1;
    assign w_nalus_full   = {r_nalus[15:8], i_byte};
    assign w_payload_full = {r_payload[15:8], i_byte};
    assign w_payload_dec  = r_payload - 16'd1;

    // Phase that follows the end of an array and the end of a NAL unit.
    assign w_after_array = (w_arrays_dec == 8'd0) ? PH_DONE : PH_TYPE;
    assign w_after_nal   = (w_nalus_dec == 16'd0) ? w_after_array : PH_LENH;

    // Next state and beat description for the byte that is taken.
    always_comb begin
        n_phase   = r_phase;
        n_skip    = r_skip;
        n_arrays  = r_arrays;
        n_nalus   = r_nalus;
        n_payload = r_payload;
        w_burst   = '0;
        w_burst.data = i_byte;

        case (r_phase)
            PH_HDR: begin
                n_skip = w_skip_inc;
                if (w_skip_inc >= HDR_BYTES) begin
                    n_skip  = 5'd0;
                    n_phase = PH_LSZ;
                end
            end
            PH_LSZ: begin
                n_phase = PH_NARR;
            end
            PH_NARR: begin
                n_arrays = i_byte;
                n_phase  = (i_byte == 8'd0) ? PH_DONE : PH_TYPE;
            end
            PH_TYPE: begin
                n_phase = PH_CNTH;
            end
            PH_CNTH: begin
                n_nalus = {i_byte, 8'd0};
                n_phase = PH_CNTL;
            end
            PH_CNTL: begin
                n_nalus = w_nalus_full;
                if (w_nalus_full == 16'd0) begin
                    n_arrays = w_arrays_dec;
                    n_phase  = w_after_array;
                end else begin
                    n_phase = PH_LENH;
                end
            end
            PH_LENH: begin
                w_burst.sc = 1'b1;
                n_payload  = {i_byte, 8'd0};
                n_phase    = PH_LENL;
            end
            PH_LENL: begin
                n_payload = w_payload_full;
                if (w_payload_full == 16'd0) begin
                    n_nalus = w_nalus_dec;
                    if (w_nalus_dec == 16'd0) begin
                        n_arrays = w_arrays_dec;
                    end
                    n_phase = w_after_nal;
                end else begin
                    n_phase = PH_PAY;
                end
            end
            PH_PAY: begin
                w_burst.pay = 1'b1;
                n_payload   = w_payload_dec;
                if (w_payload_dec == 16'd0) begin
                    n_nalus = w_nalus_dec;
                    if (w_nalus_dec == 16'd0) begin
                        n_arrays = w_arrays_dec;
                    end
                    n_phase = w_after_nal;
                end
            end
            PH_DONE: begin
            end
            default: begin
                n_phase   = PH_HDR;
                n_skip    = 5'd0;
                n_arrays  = 8'd0;
                n_nalus   = 16'd0;
                n_payload = 16'd0;
            end
        endcase

        // The byte marked last appends a status and restarts the parser.
        if (i_last) begin
            w_burst.stat = (n_phase == PH_DONE) ? KIND_DONE : KIND_TRUNC;
            n_phase   = PH_HDR;
            n_skip    = 5'd0;
            n_arrays  = 8'd0;
            n_nalus   = 16'd0;
            n_payload = 16'd0;
        end
    end

    assign o_burst = w_burst;

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR;
            r_skip    <= 5'd0;
            r_arrays  <= 8'd0;
            r_nalus   <= 16'd0;
            r_payload <= 16'd0;
        end else if (i_take) begin
            r_phase   <= n_phase;
            r_skip    <= n_skip;
            r_arrays  <= n_arrays;
            r_nalus   <= n_nalus;
            r_payload <= n_payload;
        end
    end

endmodule
